// File: src/isi_pkg.sv
// Shared types and constants for the inverse-square interpolator.
// No dependencies; imported by inverse_square_interpolator.
package isi_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int COORD_W  = 24;
    localparam int DIFF_W   = 25;
    localparam int D2_W     = 50;
    localparam int WEIGHT_W = 33;
    localparam int WSUM_W   = 40;
    localparam int VSUM_W   = 64;
    localparam int MUL_A_W  = 34;
    localparam int MUL_B_W  = 25;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    // Steps of the shared restoring divider.
    localparam int WEIGHT_DIV_STEPS = WEIGHT_W;
    localparam int FINAL_DIV_STEPS  = COORD_W;
    localparam int STEP_W           = 6;

    localparam logic [1:0] CFG_GRID_X = 2'd0;
    localparam logic [1:0] CFG_GRID_Y = 2'd1;
    localparam logic [1:0] CFG_GRID_Z = 2'd2;

    localparam logic [1:0] STATUS_WEIGHTED = 2'd0;
    localparam logic [1:0] STATUS_HIT      = 2'd1;
    localparam logic [1:0] STATUS_ZERO_SUM = 2'd2;
    localparam logic [1:0] STATUS_TOO_MANY = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] sample_x;
        logic signed [COORD_W-1:0] sample_y;
        logic signed [COORD_W-1:0] sample_z;
        logic signed [COORD_W-1:0] sample_value;
        logic                      last_sample;
    } t_sample;

    typedef struct packed {
        logic signed [COORD_W-1:0] interpolated;
        logic [1:0]                status;
    } t_result;

endpackage

// File: src/inverse_square_interpolator.sv
// Inverse-distance-squared interpolator, top level and only module.
// Depends on isi_pkg for payload types, widths and status codes.
//
//  Channel  Direction  Handshake                    Payload
//  -------  ---------  ---------------------------  ---------------------------
//  in       sink       i_in_valid / o_in_stall      t_sample  (x, y, z, value, last)
//  out      source     o_out_valid / i_out_stall    t_result  (interpolated, status)
//  cfg      sink       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// Each sample is finished before the next is accepted. A sample inside the
// distance range takes three squaring passes on the shared multiplier, with
// their sums, 33 steps of the shared restoring divider for the weight, and the
// forming and accumulating of weight times value. A sample at distance zero or
// beyond the weight range skips the divide; one past the count limit only marks
// the set. A set that ends in a weighted mean adds 24 divider steps for the final
// quotient; the result then sits in an output register, so a stall on the result
// side only holds the block once a second result is ready.
// Reset is synchronous and active low; it clears the query point and all sums.

module inverse_square_interpolator
    import isi_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_sample                   i_in,

    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_result                   o_out,

    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [COORD_W-1:0]        i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_D2_SUM,
        ST_CHECK,
        ST_DIV,
        ST_MUL_W,
        ST_ACC_W,
        ST_RESULT,
        ST_FDIV,
        ST_FQUOT,
        ST_OUT
    } t_state;

    t_state r_state;

    // Query point.
    logic signed [COORD_W-1:0] r_grid_x;
    logic signed [COORD_W-1:0] r_grid_y;
    logic signed [COORD_W-1:0] r_grid_z;

    // Current sample.
    logic signed [DIFF_W-1:0]  r_dx;
    logic signed [DIFF_W-1:0]  r_dy;
    logic signed [DIFF_W-1:0]  r_dz;
    logic signed [COORD_W-1:0] r_val;
    logic                      r_last;
    logic [D2_W-1:0]           r_d2;

    // Per-set accumulators.
    logic [WSUM_W-1:0]         r_weight_total;
    logic signed [VSUM_W-1:0]  r_weighted_total;
    logic                      r_hit_seen;
    logic signed [COORD_W-1:0] r_hit_value;
    logic [CNT_W-1:0]          r_sample_count;
    logic                      r_count_overflow;

    // Shared multiplier.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  r_prod;

    // Shared restoring divider: r_quo shifts dividend bits out of its top while
    // quotient bits enter at its bottom.
    logic [WSUM_W:0]           r_rem;
    logic [VSUM_W-1:0]         r_quo;
    logic [WSUM_W-1:0]         r_div;
    logic [STEP_W-1:0]         r_step;
    logic [WSUM_W:0]           rem_shift;
    logic [WSUM_W+1:0]         rem_diff;
    logic                      rem_ge;
    logic [WSUM_W:0]           n_rem;
    logic [VSUM_W-1:0]         n_quo;

    // Final quotient sign and pending result.
    logic                      r_neg;
    logic [VSUM_W-1:0]         mag;
    t_result                   r_res;

    // Output register.
    logic                      r_out_valid;
    t_result                   r_out;
    logic                      out_load;

    logic                      in_accept;
    logic signed [DIFF_W-1:0]  n_dx;
    logic signed [DIFF_W-1:0]  n_dy;
    logic signed [DIFF_W-1:0]  n_dz;
    logic [COORD_W-1:0]        quot;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign in_accept   = i_in_valid && !o_in_stall;

    // The pending result moves to the output register once that register is
    // empty or is being taken in the same cycle.
    assign out_load    = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);

    assign n_dx = {i_in.sample_x[COORD_W-1], i_in.sample_x} - {r_grid_x[COORD_W-1], r_grid_x};
    assign n_dy = {i_in.sample_y[COORD_W-1], i_in.sample_y} - {r_grid_y[COORD_W-1], r_grid_y};
    assign n_dz = {i_in.sample_z[COORD_W-1], i_in.sample_z} - {r_grid_z[COORD_W-1], r_grid_z};

    // The multiplier squares the three differences in turn, then forms
    // weight times value.
    always_comb begin
        unique case (r_state)
            ST_SQ_X: begin
                mul_a = MUL_A_W'(r_dx);
                mul_b = r_dx;
            end
            ST_SQ_Y: begin
                mul_a = MUL_A_W'(r_dy);
                mul_b = r_dy;
            end
            ST_SQ_Z: begin
                mul_a = MUL_A_W'(r_dz);
                mul_b = r_dz;
            end
            ST_MUL_W: begin
                mul_a = {1'b0, r_quo[WEIGHT_W-1:0]};
                mul_b = {r_val[COORD_W-1], r_val};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // One restoring division step: shift in the next dividend bit, subtract
    // the divisor when it fits.
    always_comb begin
        rem_shift = {r_rem[WSUM_W-1:0], r_quo[VSUM_W-1]};
        rem_diff  = {1'b0, rem_shift} - {2'b00, r_div};
        rem_ge    = !rem_diff[WSUM_W+1];
        n_rem     = rem_ge ? rem_diff[WSUM_W:0] : rem_shift;
        n_quo     = {r_quo[VSUM_W-2:0], rem_ge};
    end

    assign mag  = r_weighted_total[VSUM_W-1] ? (VSUM_W'(0) - VSUM_W'(r_weighted_total))
                                             : VSUM_W'(r_weighted_total);
    assign quot = r_quo[COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_grid_x         <= '0;
            r_grid_y         <= '0;
            r_grid_z         <= '0;
            r_weight_total   <= '0;
            r_weighted_total <= '0;
            r_hit_seen       <= 1'b0;
            r_hit_value      <= '0;
            r_sample_count   <= '0;
            r_count_overflow <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_prod <= mul_a * mul_b;

            if (out_load) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_GRID_X: r_grid_x <= i_cfg_data;
                    CFG_GRID_Y: r_grid_y <= i_cfg_data;
                    CFG_GRID_Z: r_grid_z <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_dx   <= n_dx;
                        r_dy   <= n_dy;
                        r_dz   <= n_dz;
                        r_val  <= i_in.sample_value;
                        r_last <= i_in.last_sample;
                        if (r_sample_count == CNT_W'(MAX_POINTS)) begin
                            // Past the limit: the sample only marks the set.
                            r_count_overflow <= 1'b1;
                            r_state <= i_in.last_sample ? ST_RESULT : ST_IDLE;
                        end else begin
                            r_sample_count <= r_sample_count + CNT_W'(1);
                            r_state        <= ST_SQ_X;
                        end
                    end
                end
                ST_SQ_X: begin
                    r_state <= ST_SQ_Y;
                end
                ST_SQ_Y: begin
                    r_d2    <= r_prod[D2_W-1:0];
                    r_state <= ST_SQ_Z;
                end
                ST_SQ_Z: begin
                    r_d2    <= r_d2 + r_prod[D2_W-1:0];
                    r_state <= ST_D2_SUM;
                end
                ST_D2_SUM: begin
                    r_d2    <= r_d2 + r_prod[D2_W-1:0];
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (r_d2 == '0) begin
                        // Exact hit: only the first one keeps its value.
                        if (!r_hit_seen) begin
                            r_hit_seen  <= 1'b1;
                            r_hit_value <= r_val;
                        end
                        r_state <= r_last ? ST_RESULT : ST_IDLE;
                    end else if (r_d2 > (D2_W'(1) << (WEIGHT_W - 1))) begin
                        // The weight truncates to zero and adds nothing.
                        r_state <= r_last ? ST_RESULT : ST_IDLE;
                    end else begin
                        r_div   <= r_d2[WSUM_W-1:0];
                        r_rem   <= '0;
                        r_quo   <= {1'b1, (VSUM_W-1)'(0)};
                        r_step  <= STEP_W'(WEIGHT_DIV_STEPS - 1);
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_step <= r_step - STEP_W'(1);
                    if (r_step == '0) begin
                        r_state <= ST_MUL_W;
                    end
                end
                ST_MUL_W: begin
                    r_weight_total <= r_weight_total + WSUM_W'(r_quo[WEIGHT_W-1:0]);
                    r_state        <= ST_ACC_W;
                end
                ST_ACC_W: begin
                    r_weighted_total <= r_weighted_total + VSUM_W'(r_prod);
                    r_state          <= r_last ? ST_RESULT : ST_IDLE;
                end
                ST_RESULT: begin
                    priority if (r_count_overflow) begin
                        r_res.interpolated <= '0;
                        r_res.status       <= STATUS_TOO_MANY;
                        r_state            <= ST_OUT;
                    end else if (r_hit_seen) begin
                        r_res.interpolated <= r_hit_value;
                        r_res.status       <= STATUS_HIT;
                        r_state            <= ST_OUT;
                    end else if (r_weight_total == '0) begin
                        r_res.interpolated <= '0;
                        r_res.status       <= STATUS_ZERO_SUM;
                        r_state            <= ST_OUT;
                    end else begin
                        // The mean fits 24 bits, so the top 40 bits of the
                        // magnitude are already below the divisor.
                        r_neg   <= r_weighted_total[VSUM_W-1];
                        r_div   <= r_weight_total;
                        r_rem   <= {1'b0, mag[VSUM_W-1:COORD_W]};
                        r_quo   <= {mag[COORD_W-1:0], WSUM_W'(0)};
                        r_step  <= STEP_W'(FINAL_DIV_STEPS - 1);
                        r_state <= ST_FDIV;
                    end
                end
                ST_FDIV: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_step <= r_step - STEP_W'(1);
                    if (r_step == '0) begin
                        r_state <= ST_FQUOT;
                    end
                end
                ST_FQUOT: begin
                    r_res.interpolated <= r_neg ? (COORD_W'(0) - quot) : quot;
                    r_res.status       <= STATUS_WEIGHTED;
                    r_state            <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_weight_total   <= '0;
                        r_weighted_total <= '0;
                        r_hit_seen       <= 1'b0;
                        r_hit_value      <= '0;
                        r_sample_count   <= '0;
                        r_count_overflow <= 1'b0;
                        r_state          <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: dv/inverse_square_interpolator_tb.sv
// Self-checking testbench for the inverse-square interpolator.
// Needs isi_pkg and inverse_square_interpolator; drives all three channels and
// scores each result against an in-bench model of the weighted interpolation.
`timescale 1ns / 100ps

module inverse_square_interpolator_tb;
    import isi_pkg::*;

    // The block under test uses its default sample limit; the model shares it.
    localparam int MAX_SAMPLES = MAX_POINTS_DEF;

    // Register index that maps to no register; the block must ignore it.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    localparam int MAX_REPORTS     = 10;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 58;
    localparam int PRESSURE_PHASE  = 3;
    localparam int QUIET_PHASE     = 4;
    // Receiver hold-off used to fill the block and back up the request side.
    localparam int HOLD_CYCLES     = 1500;
    // Settling margin; ample for a far sample with the final divide.
    localparam int SETTLE_CYCLES   = 120;
    // The longest honest silence is the receiver hold-off plus one set's work.
    localparam int STALL_LIMIT     = 5000;

    // Tracks the query point and the running sums of the open sample set, and
    // queues the result that each closing sample must produce.
    class interp_scoreboard;
        logic signed [COORD_W-1:0] grid_x, grid_y, grid_z;
        logic [WSUM_W-1:0]         weight_sum;
        logic signed [VSUM_W-1:0]  weighted_sum;
        bit                        hit_seen;
        logic signed [COORD_W-1:0] hit_value;
        int unsigned               sample_count;
        bit                        count_overflow;
        t_result                   predicted_q[$];
        int unsigned               mismatches;
        int unsigned               samples_folded;
        int unsigned               results_checked;
        int unsigned               status_seen[4];

        function new();
            grid_x = '0;
            grid_y = '0;
            grid_z = '0;
            mismatches = 0;
            samples_folded = 0;
            results_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            clear_set();
        endfunction

        function void clear_set();
            weight_sum = '0;
            weighted_sum = '0;
            hit_seen = 1'b0;
            hit_value = '0;
            sample_count = 0;
            count_overflow = 1'b0;
        endfunction

        function void write_grid(logic [1:0] idx, logic [COORD_W-1:0] data);
            case (idx)
                CFG_GRID_X: grid_x = data;
                CFG_GRID_Y: grid_y = data;
                CFG_GRID_Z: grid_z = data;
                default: ;
            endcase
        endfunction

        function void fold_sample(t_sample s);
            longint          dx, dy, dz, product;
            longint unsigned dist_sq, weight, magnitude, quotient;
            bit              negative;
            t_result         r;
            samples_folded++;
            if (sample_count >= MAX_SAMPLES) begin
                count_overflow = 1'b1;
            end else begin
                dx = longint'(s.sample_x) - longint'(grid_x);
                dy = longint'(s.sample_y) - longint'(grid_y);
                dz = longint'(s.sample_z) - longint'(grid_z);
                dist_sq = dx * dx + dy * dy + dz * dz;
                sample_count++;
                if (dist_sq == 0) begin
                    if (!hit_seen) begin
                        hit_seen = 1'b1;
                        hit_value = s.sample_value;
                    end
                end else begin
                    weight = 64'h1_0000_0000 / dist_sq;
                    product = longint'(weight) * longint'(s.sample_value);
                    weight_sum += weight[WSUM_W-1:0];
                    weighted_sum += product;
                end
            end
            if (!s.last_sample) return;
            r.interpolated = '0;
            if (count_overflow) begin
                r.status = STATUS_TOO_MANY;
            end else if (hit_seen) begin
                r.status = STATUS_HIT;
                r.interpolated = hit_value;
            end else if (weight_sum == 0) begin
                r.status = STATUS_ZERO_SUM;
            end else begin
                negative = weighted_sum < 0;
                magnitude = negative ? -weighted_sum : weighted_sum;
                quotient = magnitude / weight_sum;
                r.interpolated = negative ? -quotient[COORD_W-1:0] : quotient[COORD_W-1:0];
                r.status = STATUS_WEIGHTED;
            end
            predicted_q = {predicted_q, r};
            clear_set();
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (predicted_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result with nothing pending: interpolated=%0d status=%0d",
                             got.interpolated, got.status);
                return;
            end
            want = predicted_q.pop_front();
            results_checked++;
            status_seen[want.status]++;
            if (got.interpolated !== want.interpolated || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: result %0d: expected interpolated=%0d status=%0d,",
                             results_checked, want.interpolated, want.status);
                    $display("       got interpolated=%0d status=%0d",
                             got.interpolated, got.status);
                end
            end
        endfunction
    endclass

    // Clock, reset and the three channels. Every input starts at a known value.
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_sample              in_req = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_result              out_res;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = '0;
    logic [COORD_W-1:0]   cfg_data = '0;

    // Traffic shaping shared by the sender and the receiver processes.
    bit                   quiet = 1'b0;
    bit                   hold_request = 1'b0;

    interp_scoreboard     sb;

    always #4 clk = ~clk;

    inverse_square_interpolator #(
        .MAX_POINTS(MAX_SAMPLES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_res),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offsets from the query point span every scale up to twice the distance at
    // which the weight drops to zero, so near, boundary and far samples all occur.
    function automatic int near_offset();
        int mag;
        mag = $urandom & ((1 << $urandom_range(0, 17)) - 1);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic t_sample sample_of(int x, int y, int z, int v, bit is_last);
        t_sample s;
        s.sample_x = COORD_W'(x);
        s.sample_y = COORD_W'(y);
        s.sample_z = COORD_W'(z);
        s.sample_value = COORD_W'(v);
        s.last_sample = is_last;
        return s;
    endfunction

    // Random sample: a few exact hits on the query point, some anywhere in the
    // coordinate space, the rest clustered around the query point.
    function automatic t_sample random_sample(bit is_last);
        t_sample     s;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        s.last_sample = is_last;
        if ($urandom_range(0, 19) == 0)
            s.sample_value = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        else
            s.sample_value = COORD_W'($urandom);
        if (pick < 8) begin
            s.sample_x = sb.grid_x;
            s.sample_y = sb.grid_y;
            s.sample_z = sb.grid_z;
        end else if (pick < 20) begin
            s.sample_x = COORD_W'($urandom);
            s.sample_y = COORD_W'($urandom);
            s.sample_z = COORD_W'($urandom);
        end else begin
            s.sample_x = COORD_W'(sb.grid_x + near_offset());
            s.sample_y = COORD_W'(sb.grid_y + near_offset());
            s.sample_z = COORD_W'(sb.grid_z + near_offset());
        end
        return s;
    endfunction

    // Set sizes: mostly small, a few long ones that run up to and past the limit.
    function automatic int unsigned pick_set_size();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return $urandom_range(1, 3);
        if (pick < 80) return $urandom_range(4, 10);
        if (pick < 95) return $urandom_range(11, 40);
        return $urandom_range(50, MAX_SAMPLES + 4);
    endfunction

    // Offers one sample request, after a random gap outside the quiet phase, and
    // holds it until the block takes it. Valid stays high between back-to-back
    // requests, so it is never lowered and raised within the same falling edge.
    task automatic send_sample(t_sample s);
        int unsigned gap;
        gap = quiet ? 0 : gap_len();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req <= s;
        do @(posedge clk); while (in_stall);
        sb.fold_sample(s);
    endtask

    task automatic run_set(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_sample(random_sample(i == n - 1));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [COORD_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_grid(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(logic [COORD_W-1:0] gx, logic [COORD_W-1:0] gy,
                            logic [COORD_W-1:0] gz);
        write_reg(CFG_GRID_X, gx);
        write_reg(CFG_GRID_Y, gy);
        write_reg(CFG_GRID_Z, gz);
        if ($urandom_range(0, 1)) write_reg(CFG_UNUSED, COORD_W'($urandom));
    endtask

    // Drops the request valid, waits until every predicted result has come back,
    // then lets the block settle so that a register write finds it idle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.predicted_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Directed cases with the query point still at its reset value of zero.
    task automatic run_directed();
        // Exact hit alone, and the nearest possible sample with the most
        // negative value, which gets the largest weight of all.
        send_sample(sample_of(0, 0, 0, COORD_MAX, 1'b1));
        send_sample(sample_of(1, 0, 0, COORD_MIN, 1'b1));
        // Far corner: the weight is zero, so the weight sum is zero.
        send_sample(sample_of(COORD_MAX, COORD_MIN, COORD_MAX, -1, 1'b1));
        // Only the first of two hits supplies the value; weights are ignored.
        send_sample(sample_of(COORD_MIN, COORD_MIN, COORD_MIN, -1, 1'b0));
        send_sample(sample_of(0, 0, 0, 5, 1'b0));
        send_sample(sample_of(0, 0, 0, 7, 1'b0));
        send_sample(sample_of(2, 0, 0, 100, 1'b1));
        // A true weighted mean with mixed signs on every axis.
        send_sample(sample_of(256, 0, 0, 2560, 1'b0));
        send_sample(sample_of(0, -512, 0, -768, 1'b0));
        send_sample(sample_of(0, 0, 256, COORD_MIN, 1'b0));
        send_sample(sample_of(-256, 256, -256, COORD_MAX, 1'b1));
        // Edge of the weight range: a weight of exactly one, then just past it.
        send_sample(sample_of(65536, 0, 0, 1000, 1'b1));
        send_sample(sample_of(65537, 0, 0, 1000, 1'b1));
        // A weight-one sample next to a close one with zero value.
        send_sample(sample_of(0, 65536, 0, -1000, 1'b0));
        send_sample(sample_of(3, -4, 0, 0, 1'b1));
        // A write to the unused index must leave the query point alone.
        drain();
        write_reg(CFG_UNUSED, 24'h123456);
        send_sample(sample_of(0, 0, 0, 42, 1'b1));
    endtask

    // Every accepted result is scored against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_res);
    end

    // Result side: random stall runs of mixed length, none in the quiet phase,
    // and one long hold-off on request so the block fills and stalls its input.
    initial begin : result_sink
        int unsigned run_left;
        bit          stalling;
        run_left = 0;
        stalling = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
                run_left = 0;
            end else if (quiet) begin
                out_stall <= 1'b0;
                run_left = 0;
            end else begin
                if (run_left == 0) begin
                    stalling = $urandom_range(0, 99) < 30;
                    run_left = stalling ? gap_len() + 1 : $urandom_range(1, 24);
                end
                out_stall <= stalling;
                run_left--;
            end
        end
    end

    // Ends the run if no request, result or register write moves for too long.
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("ERROR: nothing moved for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence: reset, directed cases, then phases over several query
    // points including both corners of the coordinate range. Each phase starts
    // from an idle block, reprograms the query point and streams random sets.
    initial begin : stimulus
        logic signed [COORD_W-1:0] gx, gy, gz;
        int unsigned               phase_items;
        int unsigned               n;
        int unsigned               failures;
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: begin
                    gx = COORD_MAX;
                    gy = COORD_MAX;
                    gz = COORD_MAX;
                end
                1: begin
                    gx = COORD_MIN;
                    gy = COORD_MIN;
                    gz = COORD_MIN;
                end
                2: begin
                    gx = COORD_MIN;
                    gy = COORD_MAX;
                    gz = '0;
                end
                default: begin
                    if ($urandom_range(0, 1)) begin
                        gx = COORD_W'(int'($urandom_range(0, 4000)) - 2000);
                        gy = COORD_W'(int'($urandom_range(0, 4000)) - 2000);
                        gz = COORD_W'(int'($urandom_range(0, 4000)) - 2000);
                    end else begin
                        gx = COORD_W'($urandom);
                        gy = COORD_W'($urandom);
                        gz = COORD_W'($urandom);
                    end
                end
            endcase
            set_grid(gx, gy, gz);
            quiet = (p == QUIET_PHASE);
            if (p == PRESSURE_PHASE) hold_request = 1'b1;
            // One set exactly at the sample limit and one that runs past it.
            if (p == 0) run_set(MAX_SAMPLES);
            if (p == 2) run_set(MAX_SAMPLES + 3);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                n = pick_set_size();
                run_set(n);
                phase_items += n;
            end
        end
        quiet = 1'b0;
        drain();

        failures = sb.mismatches + sb.predicted_q.size();
        $display("Streamed %0d samples over %0d query points, %0d results scored.",
                 sb.samples_folded, PHASES + 1, sb.results_checked);
        $display("Outcomes: %0d weighted, %0d exact hit, %0d zero weight, %0d over limit.",
                 sb.status_seen[STATUS_WEIGHTED], sb.status_seen[STATUS_HIT],
                 sb.status_seen[STATUS_ZERO_SUM], sb.status_seen[STATUS_TOO_MANY]);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
